FILE: src/wmmd_pkg.sv
// Shared constants, types and register codes for the waveform min/max decimator.
`default_nettype none

package wmmd_pkg;

   // Sample and geometry limits
   localparam int SAMPLE_BITS    = 16;
   localparam int SCALE_SHIFT    = SAMPLE_BITS - 1;
   localparam int MAX_COLUMNS    = 4096;
   localparam int COLUMN_BITS    = $clog2(MAX_COLUMNS);
   localparam int COUNT_BITS     = COLUMN_BITS + 1;
   localparam int FRAME_BITS     = 32;
   localparam int CHANNEL_BITS   = 4;
   localparam int MAX_CHANNELS   = 8;
   localparam int CHAN_POS_BITS  = $clog2(MAX_CHANNELS);
   localparam int HEIGHT_BITS    = 12;
   localparam int MIN_HALF       = 2;
   localparam int MAX_HALF       = 2048;

   // Register reset values
   localparam int RESET_COLUMNS  = 640;
   localparam int RESET_FRAMES   = 1;
   localparam int RESET_CHANNELS = 1;
   localparam int RESET_HALF     = 80;

   // Control port
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_COLUMN_COUNT  = 2'd0,
      REG_FRAME_TOTAL   = 2'd1,
      REG_CHANNEL_COUNT = 2'd2,
      REG_HALF_HEIGHT   = 2'd3
   } reg_index_type;

   // Column bursts and the queue between sequencer and row mapper
   localparam int RESULT_LIMIT   = 64;
   localparam int BURST_BITS     = $clog2(RESULT_LIMIT) + 1;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // Divider step counter
   localparam int DIV_STEP_BITS  = $clog2(FRAME_BITS) + 1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic [COUNT_BITS-1:0]   column_count;
      logic [FRAME_BITS-1:0]   frame_total;
      logic [CHANNEL_BITS-1:0] channel_count;
      logic [HEIGHT_BITS-1:0]  half_height;
   } config_type;

   typedef struct packed {
      logic                   busy;
      logic [FRAME_BITS-1:0]  quotient;
      logic [COLUMN_BITS-1:0] remainder;
   } div_status_type;

   typedef struct packed {
      logic [COLUMN_BITS-1:0] column;
      logic                   last;
      sample_type             peak_max;
      sample_type             peak_min;
   } column_entry_type;

endpackage

`default_nettype wire

FILE: src/wmmd_div.sv
// Restoring divider, one quotient bit per cycle: frame total over column count.
`default_nettype none

module wmmd_div
   import wmmd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [FRAME_BITS-1:0] dividend,
   input  wire logic [COUNT_BITS-1:0] divisor,
   output div_status_type             status
);

   logic                     busy_ff, busy_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic [FRAME_BITS-1:0]    quot_ff, quot_in;
   logic [COLUMN_BITS-1:0]   rem_ff, rem_in;

   logic [COUNT_BITS-1:0]    trial;
   logic                     fits;
   logic [COUNT_BITS-1:0]    trial_diff;

   // Shift in the next dividend bit and try the subtract
   assign trial      = {rem_ff, quot_ff[FRAME_BITS-1]};
   assign fits       = trial >= divisor;
   assign trial_diff = trial - divisor;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = DIV_STEP_BITS'(FRAME_BITS);
         quot_in = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[FRAME_BITS-2:0], fits};
         rem_in  = fits ? trial_diff[COLUMN_BITS-1:0] : trial[COLUMN_BITS-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == DIV_STEP_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign status.busy      = busy_ff;
   assign status.quotient  = quot_ff;
   assign status.remainder = rem_ff;

endmodule

`default_nettype wire

FILE: src/wmmd_front.sv
// Front sequencer: takes samples, tracks extremes and frames, issues closed columns.
`default_nettype none

module wmmd_front
   import wmmd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       restart,
   input  wire config_type cfg,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire sample_type req_sample,
   output logic            div_start,
   input  wire div_status_type div,
   output logic            push_valid,
   output column_entry_type push_entry,
   input  wire logic       queue_full
);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_PREP,
      ST_RUN,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [CHAN_POS_BITS-1:0] chan_ff, chan_in;
   logic [FRAME_BITS-1:0]   frame_ff, frame_in;
   logic [COUNT_BITS-1:0]   col_ff, col_in;
   logic [FRAME_BITS-1:0]   qnext_ff, qnext_in;
   logic [COLUMN_BITS-1:0]  rnext_ff, rnext_in;
   logic [FRAME_BITS-1:0]   end_ff, end_in;
   logic [BURST_BITS-1:0]   burst_ff, burst_in;
   sample_type              vmin_ff, vmin_in;
   sample_type              vmax_ff, vmax_in;

   logic                    accept;
   logic                    cols_left;
   logic                    due;
   logic                    take;
   logic                    frame_wrap;
   logic [FRAME_BITS-1:0]   frame_next;
   logic                    due_next;
   logic [COUNT_BITS-1:0]   rem_sum;
   logic                    carry;
   logic [COUNT_BITS-1:0]   rem_wrapped;
   logic [FRAME_BITS-1:0]   q_advance;

   // Column bookkeeping from registered state
   assign cols_left = col_ff < cfg.column_count;
   assign due       = cols_left && (cfg.frame_total != '0) && (end_ff <= frame_ff);
   assign accept    = req_valid && (state_ff == ST_RUN);
   assign req_stall = state_ff != ST_RUN;

   // Sample intake and frame count
   assign take       = accept && !due && cols_left && (frame_ff < cfg.frame_total);
   assign frame_wrap = ({1'b0, chan_ff} + CHANNEL_BITS'(1)) >= cfg.channel_count;
   assign frame_next = (take && frame_wrap) ? frame_ff + 1'b1 : frame_ff;
   assign due_next   = cols_left && (cfg.frame_total != '0) && (end_ff <= frame_next);

   // Next column boundary, exact floor((x+1)*F/W) kept as quotient and remainder
   assign rem_sum     = {1'b0, rnext_ff} + {1'b0, div.remainder};
   assign carry       = rem_sum >= cfg.column_count;
   assign rem_wrapped = rem_sum - cfg.column_count;
   assign q_advance   = qnext_ff + div.quotient + FRAME_BITS'(carry);

   // Closed column as handed to the row mapper
   assign push_entry.column   = col_ff[COLUMN_BITS-1:0];
   assign push_entry.last     = col_ff == (cfg.column_count - 1'b1);
   assign push_entry.peak_max = vmax_ff;
   assign push_entry.peak_min = vmin_ff;

   always_comb begin
      state_in   = state_ff;
      chan_in    = chan_ff;
      frame_in   = frame_ff;
      col_in     = col_ff;
      qnext_in   = qnext_ff;
      rnext_in   = rnext_ff;
      end_in     = end_ff;
      burst_in   = burst_ff;
      vmin_in    = vmin_ff;
      vmax_in    = vmax_ff;
      div_start  = 1'b0;
      push_valid = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            // restart the stream and launch the boundary division
            div_start = 1'b1;
            chan_in   = '0;
            frame_in  = '0;
            col_in    = '0;
            burst_in  = '0;
            vmin_in   = SAMPLE_MAX;
            vmax_in   = SAMPLE_MIN;
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            // load the end of column zero once the quotient is ready
            if (!div.busy) begin
               qnext_in = div.quotient;
               rnext_in = div.remainder;
               end_in   = (div.quotient == '0) ? FRAME_BITS'(1) : div.quotient;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (accept) begin
               if (take) begin
                  if (req_sample < vmin_ff) vmin_in = req_sample;
                  if (req_sample > vmax_ff) vmax_in = req_sample;
                  chan_in  = frame_wrap ? '0 : chan_ff + 1'b1;
                  frame_in = frame_next;
               end
               if (due_next) begin
                  burst_in = '0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!due) begin
               // burst done: drop the extremes
               vmin_in  = SAMPLE_MAX;
               vmax_in  = SAMPLE_MIN;
               state_in = ST_RUN;
            end else if (burst_ff == BURST_BITS'(RESULT_LIMIT)) begin
               // hold extremes, the next request resumes the burst
               state_in = ST_RUN;
            end else if (!queue_full) begin
               push_valid = 1'b1;
               col_in     = col_ff + 1'b1;
               qnext_in   = q_advance;
               rnext_in   = carry ? rem_wrapped[COLUMN_BITS-1:0] : rem_sum[COLUMN_BITS-1:0];
               end_in     = ((div.quotient == '0) && !carry) ? qnext_ff + 1'b1 : q_advance;
               burst_in   = burst_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      if (restart) begin
         state_in = ST_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         chan_ff  <= '0;
         frame_ff <= '0;
         col_ff   <= '0;
         burst_ff <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         frame_ff <= frame_in;
         col_ff   <= col_in;
         burst_ff <= burst_in;
      end
      qnext_ff <= qnext_in;
      rnext_ff <= rnext_in;
      end_ff   <= end_in;
      vmin_ff  <= vmin_in;
      vmax_ff  <= vmax_in;
   end

endmodule

`default_nettype wire

FILE: src/wmmd_back.sv
// Back end: column queue, row mapping pipeline and result output register.
`default_nettype none

module wmmd_back
   import wmmd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [HEIGHT_BITS-1:0] half_height,
   input  wire logic                   push_valid,
   input  wire column_entry_type       push_entry,
   output logic                        queue_full,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [COLUMN_BITS-1:0]      rsp_column,
   output logic [HEIGHT_BITS-1:0]      rsp_row_top,
   output logic [HEIGHT_BITS-1:0]      rsp_row_bottom,
   output logic                        rsp_last_column
);

   localparam int PROD_BITS = SAMPLE_BITS + HEIGHT_BITS + 1;

   // Queue storage
   column_entry_type            queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]     level_ff, level_in;

   // Multiply stage
   logic                        m_valid_ff, m_valid_in;
   logic [COLUMN_BITS-1:0]      m_column_ff;
   logic                        m_last_ff;
   logic signed [PROD_BITS-1:0] m_prod_max_ff, m_prod_min_ff;

   // Output stage
   logic                        o_valid_ff, o_valid_in;
   logic [COLUMN_BITS-1:0]      o_column_ff;
   logic                        o_last_ff;
   logic [HEIGHT_BITS-1:0]      o_top_ff, o_bottom_ff;

   column_entry_type            head;
   logic                        o_ready;
   logic                        m_ready;
   logic                        pop;
   logic [HEIGHT_BITS-1:0]      scale;
   logic signed [HEIGHT_BITS:0] scale_s;
   logic signed [PROD_BITS-1:0] prod_max, prod_min;
   logic [HEIGHT_BITS-1:0]      row_top, row_bottom;

   // mid minus the product scaled down with truncation toward zero
   function automatic logic [HEIGHT_BITS-1:0] to_row(
      input logic signed [PROD_BITS-1:0] prod,
      input logic [HEIGHT_BITS-1:0]      mid
   );
      logic signed [PROD_BITS-1:0] bias;
      logic signed [PROD_BITS-1:0] quot;
      bias = prod[PROD_BITS-1] ? PROD_BITS'((1 << SCALE_SHIFT) - 1) : '0;
      quot = (prod + bias) >>> SCALE_SHIFT;
      return mid - quot[HEIGHT_BITS-1:0];
   endfunction

   // Pipeline handshake
   assign o_ready    = !o_valid_ff || !rsp_stall;
   assign m_ready    = !m_valid_ff || o_ready;
   assign pop        = (level_ff != '0) && m_ready;
   assign queue_full = level_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
   assign head       = queue_ff[rd_ptr_ff];

   // Queue pointers and fill level
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff + (QUEUE_PTR_BITS+1)'(push_valid) - (QUEUE_PTR_BITS+1)'(pop);
   end

   // Scale both extremes by mid - 2
   assign scale    = half_height - HEIGHT_BITS'(MIN_HALF);
   assign scale_s  = {1'b0, scale};
   assign prod_max = PROD_BITS'($signed(head.peak_max) * scale_s);
   assign prod_min = PROD_BITS'($signed(head.peak_min) * scale_s);

   assign row_top    = to_row(m_prod_max_ff, half_height);
   assign row_bottom = to_row(m_prod_min_ff, half_height);

   always_comb begin
      m_valid_in = m_ready ? pop : m_valid_ff;
      o_valid_in = o_ready ? m_valid_ff : o_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         level_ff   <= '0;
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         level_ff   <= level_in;
         m_valid_ff <= m_valid_in;
         o_valid_ff <= o_valid_in;
      end
      if (push_valid) begin
         queue_ff[wr_ptr_ff] <= push_entry;
      end
      if (m_ready) begin
         m_column_ff   <= head.column;
         m_last_ff     <= head.last;
         m_prod_max_ff <= prod_max;
         m_prod_min_ff <= prod_min;
      end
      if (o_ready) begin
         o_column_ff <= m_column_ff;
         o_last_ff   <= m_last_ff;
         o_top_ff    <= row_top;
         o_bottom_ff <= row_bottom;
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_column      = o_column_ff;
   assign rsp_row_top     = o_top_ff;
   assign rsp_row_bottom  = o_bottom_ff;
   assign rsp_last_column = o_last_ff;

endmodule

`default_nettype wire

FILE: src/waveform_min_max_decimator_top.sv
// Top level of the waveform min/max decimator: control registers and block wiring.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   req_sample
//   rsp      out        rsp_valid/rsp_stall   rsp_column, rsp_row_top, rsp_row_bottom,
//                                             rsp_last_column
//   csr      in         csr_we                csr_index, csr_wdata
//
// A sample that closes no column leaves req_stall low; one that closes k columns (at
// most 64 per request) holds req_stall while they are issued, one column per cycle
// while the queue has room. Columns still due after 64 go out on the next request,
// which is dropped. Issued columns pass the queue, the multiply and output registers.
// After reset or any register write, the serial divider first splits the frame total
// over the columns; a full four-entry queue or a stalled output holds issue.
`default_nettype none

module waveform_min_max_decimator_top
   import wmmd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [SAMPLE_BITS-1:0]    req_sample,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [COLUMN_BITS-1:0]         rsp_column,
   output logic [HEIGHT_BITS-1:0]         rsp_row_top,
   output logic [HEIGHT_BITS-1:0]         rsp_row_bottom,
   output logic                           rsp_last_column,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   config_type              cfg_ff, cfg_in;
   logic [COUNT_BITS-1:0]   col_raw;
   logic [CHANNEL_BITS-1:0] chan_raw;
   logic [HEIGHT_BITS-1:0]  half_raw;

   logic                    div_start;
   div_status_type          div_status;
   logic                    push_valid;
   column_entry_type        push_entry;
   logic                    queue_full;

   // Clamp register writes into their legal ranges
   assign col_raw  = csr_wdata[COUNT_BITS-1:0];
   assign chan_raw = csr_wdata[CHANNEL_BITS-1:0];
   assign half_raw = csr_wdata[HEIGHT_BITS-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_COLUMN_COUNT: begin
               if (col_raw == '0) begin
                  cfg_in.column_count = COUNT_BITS'(1);
               end else if (col_raw > COUNT_BITS'(MAX_COLUMNS)) begin
                  cfg_in.column_count = COUNT_BITS'(MAX_COLUMNS);
               end else begin
                  cfg_in.column_count = col_raw;
               end
            end
            REG_FRAME_TOTAL: begin
               cfg_in.frame_total = csr_wdata[FRAME_BITS-1:0];
            end
            REG_CHANNEL_COUNT: begin
               if (chan_raw == '0) begin
                  cfg_in.channel_count = CHANNEL_BITS'(1);
               end else if (chan_raw > CHANNEL_BITS'(MAX_CHANNELS)) begin
                  cfg_in.channel_count = CHANNEL_BITS'(MAX_CHANNELS);
               end else begin
                  cfg_in.channel_count = chan_raw;
               end
            end
            REG_HALF_HEIGHT: begin
               if (half_raw < HEIGHT_BITS'(MIN_HALF)) begin
                  cfg_in.half_height = HEIGHT_BITS'(MIN_HALF);
               end else if (half_raw > HEIGHT_BITS'(MAX_HALF)) begin
                  cfg_in.half_height = HEIGHT_BITS'(MAX_HALF);
               end else begin
                  cfg_in.half_height = half_raw;
               end
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.column_count  <= COUNT_BITS'(RESET_COLUMNS);
         cfg_ff.frame_total   <= FRAME_BITS'(RESET_FRAMES);
         cfg_ff.channel_count <= CHANNEL_BITS'(RESET_CHANNELS);
         cfg_ff.half_height   <= HEIGHT_BITS'(RESET_HALF);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Column boundary divider
   wmmd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cfg_ff.frame_total),
      .divisor  (cfg_ff.column_count),
      .status   (div_status)
   );

   // Sample intake and column sequencing; any register write restarts the stream
   wmmd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_we),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (sample_type'(req_sample)),
      .div_start  (div_start),
      .div        (div_status),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   // Row mapping and result delivery
   wmmd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .half_height     (cfg_ff.half_height),
      .push_valid      (push_valid),
      .push_entry      (push_entry),
      .queue_full      (queue_full),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_column      (rsp_column),
      .rsp_row_top     (rsp_row_top),
      .rsp_row_bottom  (rsp_row_bottom),
      .rsp_last_column (rsp_last_column)
   );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the waveform min/max decimator top level.
import wmmd_pkg::*;

typedef struct {
   logic [COLUMN_BITS-1:0] column;
   logic [HEIGHT_BITS-1:0] row_top;
   logic [HEIGHT_BITS-1:0] row_bottom;
   logic                   last;
} column_rows_type;

// Tracks column extremes and boundaries, and holds the column rows still due
class peak_column_model;
   int unsigned     col_total;
   logic [31:0]     frames;
   int unsigned     chan_total;
   int unsigned     mid;

   int              lowest;
   int              highest;
   int unsigned     chan_pos;
   longint unsigned frames_done;
   int unsigned     next_col;
   longint unsigned col_end;

   column_rows_type due_columns[$];
   int              failures;

   function new();
      col_total  = 640;
      frames     = 1;
      chan_total = 1;
      mid        = 80;
      failures   = 0;
      restart();
   endfunction

   // Frame count at which column x closes; every column spans one frame or more
   function longint unsigned column_stop(int unsigned x);
      longint unsigned f, w, first, stop;
      f = frames;
      w = col_total;
      first = (64'(x) * f) / w;
      stop  = (64'(x + 1) * f) / w;
      if (stop <= first)
         stop = first + 1;
      return stop;
   endfunction

   function void clear_extremes();
      lowest  = 32767;
      highest = -32768;
   endfunction

   function void restart();
      clear_extremes();
      chan_pos    = 0;
      frames_done = 0;
      next_col    = 0;
      col_end     = column_stop(0);
   endfunction

   function bit column_closes();
      return next_col < col_total && frames != 0 && col_end <= frames_done;
   endfunction

   // Map a sample value to a pixel row, truncating toward zero
   function logic [HEIGHT_BITS-1:0] row_of(int v);
      longint m, q;
      logic [HEIGHT_BITS-1:0] row;
      m = mid;
      q = (longint'(v) * (m - 2)) / 32768;
      row = HEIGHT_BITS'(m - q);
      return row;
   endfunction

   // Apply a register write; any write restarts the stream
   function void set_register(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         REG_COLUMN_COUNT: begin
            col_total = value[12:0];
            if (col_total < 1) col_total = 1;
            if (col_total > 4096) col_total = 4096;
         end
         REG_FRAME_TOTAL: begin
            frames = value;
         end
         REG_CHANNEL_COUNT: begin
            chan_total = value[3:0];
            if (chan_total < 1) chan_total = 1;
            if (chan_total > 8) chan_total = 8;
         end
         REG_HALF_HEIGHT: begin
            mid = value[11:0];
            if (mid < 2) mid = 2;
            if (mid > 2048) mid = 2048;
         end
         default: ;
      endcase
      restart();
   endfunction

   // Fold an accepted request into the extremes and queue up to 64 columns it closes;
   // a request that arrives while columns are still due only resumes their issue
   function void take_sample(sample_type s);
      int v;
      int closed;
      column_rows_type rows;
      v = int'(s);
      closed = 0;
      if (!column_closes() && next_col < col_total && frames_done < frames) begin
         if (v < lowest) lowest = v;
         if (v > highest) highest = v;
         chan_pos++;
         if (chan_pos >= chan_total) begin
            chan_pos = 0;
            frames_done++;
         end
      end
      while (column_closes() && closed < RESULT_LIMIT) begin
         rows.column     = next_col[COLUMN_BITS-1:0];
         rows.row_top    = row_of(highest);
         rows.row_bottom = row_of(lowest);
         rows.last       = (next_col == col_total - 1);
         due_columns.push_back(rows);
         next_col++;
         if (next_col < col_total)
            col_end = column_stop(next_col);
         closed++;
      end
      if (closed > 0 && !column_closes())
         clear_extremes();
   endfunction

   // Compare one delivered column with the oldest one due
   function void check_column(logic [COLUMN_BITS-1:0] column,
                              logic [HEIGHT_BITS-1:0] row_top,
                              logic [HEIGHT_BITS-1:0] row_bottom,
                              logic last);
      column_rows_type want;
      if (due_columns.size() == 0) begin
         $error("column %0d delivered with none due", column);
         failures++;
         return;
      end
      want = due_columns.pop_front();
      if (column !== want.column) begin
         $error("column: expected %0d, got %0d", want.column, column);
         failures++;
      end
      if (row_top !== want.row_top) begin
         $error("row_top: expected %0d, got %0d", want.row_top, row_top);
         failures++;
      end
      if (row_bottom !== want.row_bottom) begin
         $error("row_bottom: expected %0d, got %0d", want.row_bottom, row_bottom);
         failures++;
      end
      if (last !== want.last) begin
         $error("last_column: expected %0d, got %0d", want.last, last);
         failures++;
      end
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 48;
   localparam int RANDOM_ITEMS = 350;
   localparam int QUIET_ITEMS = 290;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [SAMPLE_BITS-1:0]    req_sample;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [COLUMN_BITS-1:0]    rsp_column;
   logic [HEIGHT_BITS-1:0]    rsp_row_top;
   logic [HEIGHT_BITS-1:0]    rsp_row_bottom;
   logic                      rsp_last_column;
   logic                      csr_we;
   reg_index_type             csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   peak_column_model peaks = new();

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int rsp_hold_left = 0;
   int cycle_count = 0;

   waveform_min_max_decimator_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_column      (rsp_column),
      .rsp_row_top     (rsp_row_top),
      .rsp_row_bottom  (rsp_row_bottom),
      .rsp_last_column (rsp_last_column),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the result side in random bursts
   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_stall <= 1'b1;
         rsp_hold_left <= $urandom_range(0, 10);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check every delivered column
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         peaks.check_column(rsp_column, rsp_row_top, rsp_row_bottom, rsp_last_column);
   end

   // Abort a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** waveform_min_max_decimator_top: FAILED **");
      $finish;
   end

   // Present one request and hold it until taken
   task automatic send_sample(sample_type value);
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      peaks.take_sample(value);
   endtask

   task automatic idle_req(int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Drop valid, drain all due columns, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (peaks.due_columns.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      peaks.set_register(idx, value);
   endtask

   task automatic configure(logic [31:0] cols, logic [31:0] total, logic [31:0] chans,
                            logic [31:0] half);
      settle();
      write_register(REG_COLUMN_COUNT, cols);
      write_register(REG_FRAME_TOTAL, total);
      write_register(REG_CHANNEL_COUNT, chans);
      write_register(REG_HALF_HEIGHT, half);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return sample_type'($urandom_range(0, 64) - 32);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Feed random requests with random gaps
   task automatic feed_samples(int count);
      for (int i = 0; i < count; i++) begin
         if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct)
            idle_req($urandom_range(1, 11));
         send_sample(pick_sample());
      end
   endtask

   initial begin
      int random_items;
      int cols, chans, total, half, count;
      longint unsigned clip;

      req_valid = 1'b0;
      req_sample = '0;
      csr_we = 1'b0;
      csr_index = REG_COLUMN_COUNT;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 10;
      rsp_idle_pct = 10;

      // Reset settings: one frame makes 640 columns due, 64 go out per request
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);

      // Uneven boundaries, two channels, midline above range
      configure(3, 4, 2, 4095);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(16'sd0);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      send_sample(16'sh4000);
      send_sample(-16'sh4000);
      send_sample(16'sd5);
      send_sample(16'sd7);

      // Column count and midline below range, channel count above range
      configure(0, 1, 15, 0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      for (int i = 0; i < 6; i++)
         send_sample(pick_sample());

      // Column count above range: one frame makes 4096 columns due
      configure(8191, 1, 0, 2048);
      send_sample(-16'sd12345);
      send_sample(16'sd100);
      send_sample(-16'sd100);

      // Zero frames: every sample is ignored
      configure(5, 0, 1, 100);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);

      // Largest clip: no column closes within the run
      configure(4096, 32'hFFFF_FFFF, 8, 2);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);

      // Random phases, each a fresh clip
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= QUIET_ITEMS) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: req_idle_pct = 0;
               1: req_idle_pct = 10;
               default: req_idle_pct = 30;
            endcase
            case ($urandom_range(0, 2))
               0: rsp_idle_pct = 0;
               1: rsp_idle_pct = 10;
               default: rsp_idle_pct = 30;
            endcase
         end

         if ($urandom_range(0, 9) == 0) begin
            // Noise settings across all register bits
            configure($urandom, $urandom, $urandom, $urandom);
            count = 12;
         end else begin
            chans = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                               : $urandom_range(1, 8);
            cols = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 400)
                                              : $urandom_range(1, 40);
            total = $urandom_range(1, 64 / ((chans < 1) ? 1 : (chans > 8) ? 8 : chans));
            if ($urandom_range(0, 5) == 0 && cols <= total * 2)
               total = cols;
            case ($urandom_range(0, 9))
               0: half = $urandom_range(0, 1);
               1: half = $urandom_range(2049, 4095);
               2: half = 2048;
               3: half = 2;
               default: half = $urandom_range(2, 2048);
            endcase
            configure(cols, total, chans, half);
            clip = peaks.chan_total * 64'(peaks.frames);
            if ($urandom_range(0, 5) == 0)
               count = $urandom_range(1, int'(clip));
            else
               count = int'(clip) + $urandom_range(0, 3);
         end

         feed_samples(count);
         clip = peaks.chan_total * 64'(peaks.frames);
         random_items += (64'(count) < clip) ? count : int'(clip);
      end

      settle();
      if (peaks.due_columns.size() != 0)
         $error("%0d columns never delivered", peaks.due_columns.size());
      if (peaks.failures == 0 && peaks.due_columns.size() == 0)
         $display("** waveform_min_max_decimator_top: PASSED **");
      else
         $display("** waveform_min_max_decimator_top: FAILED **");
      $finish;
   end
endmodule

FILE: sim.f
src/wmmd_pkg.sv
src/wmmd_div.sv
src/wmmd_front.sv
src/wmmd_back.sv
src/waveform_min_max_decimator_top.sv
test/tb_top.sv
